@@ hdl/pwfd_pkg.sv @@
// ============================================================================
// Pulse width frame decoder package
// Shared types, constants and the command decode used by all decoder modules.
// ============================================================================
package pwfd_pkg;

    // Number of bit slots in one frame after the sync pulse
    localparam int BIT_SLOTS = 4;
    localparam int SLOT_W    = $clog2(BIT_SLOTS + 1);

    localparam int TICK_W = 8;
    localparam int CODE_W = 4;
    localparam int BITS_W = 3;
    localparam int CMD_W  = 2;
    localparam int CFG_W  = 8;
    localparam int CIDX_W = 3;

    // Output stream word: code, bits_taken, command, then zero fill
    localparam int RES_W   = CODE_W + BITS_W + CMD_W;
    localparam int MDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [CODE_W-1:0] CODE_ON  = CODE_W'(4'h5);
    localparam logic [CODE_W-1:0] CODE_OFF = CODE_W'(4'h2);

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Register reset values
    localparam logic [CFG_W-1:0] SYNC_MIN_RST      = 8'd140;
    localparam logic [CFG_W-1:0] SYNC_MAX_RST      = 8'd158;
    localparam logic [CFG_W-1:0] ONE_LEAD_MIN_RST  = 8'd26;
    localparam logic [CFG_W-1:0] ONE_LEAD_MAX_RST  = 8'd38;
    localparam logic [CFG_W-1:0] ZERO_LEAD_MIN_RST = 8'd12;
    localparam logic [CFG_W-1:0] ZERO_LEAD_MAX_RST = 8'd20;
    localparam logic [CFG_W-1:0] TAIL_MIN_RST      = 8'd17;
    localparam logic [CFG_W-1:0] TAIL_MAX_RST      = 8'd25;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SYNC_MIN      = 3'd0,
        CFG_SYNC_MAX      = 3'd1,
        CFG_ONE_LEAD_MIN  = 3'd2,
        CFG_ONE_LEAD_MAX  = 3'd3,
        CFG_ZERO_LEAD_MIN = 3'd4,
        CFG_ZERO_LEAD_MAX = 3'd5,
        CFG_TAIL_MIN      = 3'd6,
        CFG_TAIL_MAX      = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEAD = 2'd1,
        PH_TAIL = 2'd2
    } phase_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] sync_min;
        logic [CFG_W-1:0] sync_max;
        logic [CFG_W-1:0] one_lead_min;
        logic [CFG_W-1:0] one_lead_max;
        logic [CFG_W-1:0] zero_lead_min;
        logic [CFG_W-1:0] zero_lead_max;
        logic [CFG_W-1:0] tail_min;
        logic [CFG_W-1:0] tail_max;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic              lead_was_one;
        logic [SLOT_W-1:0] slot_count;
        logic [BITS_W-1:0] bit_count;
        logic [CODE_W-1:0] shift_code;
    } dec_state_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BITS_W-1:0] bits_taken;
        cmd_t              command;
    } result_t;

    function automatic cmd_t cmd_from_code(input logic [CODE_W-1:0] code);
        cmd_t cmd;
        cmd = CMD_NONE;
        if (code == CODE_ON) begin
            cmd = CMD_ON;
        end else if (code == CODE_OFF) begin
            cmd = CMD_OFF;
        end
        return cmd;
    endfunction

endpackage

@@ hdl/pwfd_cfg_regs.sv @@
// ============================================================================
// Pulse width frame decoder register file
// Eight 8-bit window limits, written through a plain write port, no read-back.
// ============================================================================
module pwfd_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [pwfd_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [pwfd_pkg::CFG_W-1:0]   cfg_data,
    output pwfd_pkg::cfg_t               cfg_o
);

    pwfd_pkg::cfg_t cfg_reg;
    pwfd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                pwfd_pkg::CFG_SYNC_MIN:      cfg_next.sync_min      = cfg_data;
                pwfd_pkg::CFG_SYNC_MAX:      cfg_next.sync_max      = cfg_data;
                pwfd_pkg::CFG_ONE_LEAD_MIN:  cfg_next.one_lead_min  = cfg_data;
                pwfd_pkg::CFG_ONE_LEAD_MAX:  cfg_next.one_lead_max  = cfg_data;
                pwfd_pkg::CFG_ZERO_LEAD_MIN: cfg_next.zero_lead_min = cfg_data;
                pwfd_pkg::CFG_ZERO_LEAD_MAX: cfg_next.zero_lead_max = cfg_data;
                pwfd_pkg::CFG_TAIL_MIN:      cfg_next.tail_min      = cfg_data;
                pwfd_pkg::CFG_TAIL_MAX:      cfg_next.tail_max      = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_min      <= pwfd_pkg::SYNC_MIN_RST;
            cfg_reg.sync_max      <= pwfd_pkg::SYNC_MAX_RST;
            cfg_reg.one_lead_min  <= pwfd_pkg::ONE_LEAD_MIN_RST;
            cfg_reg.one_lead_max  <= pwfd_pkg::ONE_LEAD_MAX_RST;
            cfg_reg.zero_lead_min <= pwfd_pkg::ZERO_LEAD_MIN_RST;
            cfg_reg.zero_lead_max <= pwfd_pkg::ZERO_LEAD_MAX_RST;
            cfg_reg.tail_min      <= pwfd_pkg::TAIL_MIN_RST;
            cfg_reg.tail_max      <= pwfd_pkg::TAIL_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_o = cfg_reg;

endmodule

@@ hdl/pwfd_slot_logic.sv @@
// ============================================================================
// Pulse width frame decoder slot logic
// Window compares and next frame state for one pulse; flags a frame end.
// ============================================================================
module pwfd_slot_logic (
    input  pwfd_pkg::cfg_t                cfg_i,
    input  pwfd_pkg::dec_state_t          state_i,
    input  logic                          start_i,
    input  logic [pwfd_pkg::TICK_W-1:0]   ticks_i,
    output pwfd_pkg::dec_state_t          state_o,
    output logic                          emit_o,
    output pwfd_pkg::result_t             result_o
);

    localparam logic [pwfd_pkg::SLOT_W-1:0] SLOTS_LAST =
        pwfd_pkg::SLOT_W'(pwfd_pkg::BIT_SLOTS);

    logic                          sync_ok;
    logic                          one_ok;
    logic                          zero_ok;
    logic                          tail_ok;
    logic [pwfd_pkg::TICK_W-1:0]   tail_lo;
    logic [pwfd_pkg::TICK_W-1:0]   tail_hi;
    logic [pwfd_pkg::SLOT_W-1:0]   slot_inc;
    logic [pwfd_pkg::CODE_W-1:0]   code_shift;
    logic [pwfd_pkg::BITS_W-1:0]   bits_inc;
    pwfd_pkg::dec_state_t          nxt;
    logic                          finish;

    assign sync_ok = (ticks_i >= cfg_i.sync_min) && (ticks_i <= cfg_i.sync_max);
    assign one_ok  = (ticks_i >= cfg_i.one_lead_min) && (ticks_i <= cfg_i.one_lead_max);
    assign zero_ok = (ticks_i >= cfg_i.zero_lead_min) && (ticks_i <= cfg_i.zero_lead_max);

    // Zero path widens the tail window by one tick each side, saturating
    always_comb begin
        tail_lo = cfg_i.tail_min;
        tail_hi = cfg_i.tail_max;
        if (!state_i.lead_was_one) begin
            if (cfg_i.tail_min != '0) begin
                tail_lo = cfg_i.tail_min - pwfd_pkg::TICK_W'(1);
            end
            if (cfg_i.tail_max != pwfd_pkg::TICK_MAX) begin
                tail_hi = cfg_i.tail_max + pwfd_pkg::TICK_W'(1);
            end
        end
    end

    assign tail_ok    = (ticks_i >= tail_lo) && (ticks_i <= tail_hi);
    assign slot_inc   = state_i.slot_count + pwfd_pkg::SLOT_W'(1);
    assign code_shift = {state_i.shift_code[pwfd_pkg::CODE_W-2:0], state_i.lead_was_one};
    assign bits_inc   = (state_i.bit_count == '1) ? state_i.bit_count
                                                  : state_i.bit_count + pwfd_pkg::BITS_W'(1);

    always_comb begin
        nxt    = state_i;
        finish = 1'b0;
        if (start_i) begin
            nxt.shift_code   = '0;
            nxt.bit_count    = '0;
            nxt.slot_count   = '0;
            nxt.lead_was_one = 1'b0;
            if (sync_ok) begin
                nxt.phase = pwfd_pkg::PH_LEAD;
            end else begin
                finish = 1'b1;
            end
        end else begin
            unique case (state_i.phase)
                pwfd_pkg::PH_LEAD: begin
                    if (one_ok) begin
                        nxt.lead_was_one = 1'b1;
                        nxt.phase        = pwfd_pkg::PH_TAIL;
                    end else if (zero_ok) begin
                        nxt.lead_was_one = 1'b0;
                        nxt.phase        = pwfd_pkg::PH_TAIL;
                    end else begin
                        // unrecognized lead uses up the slot
                        nxt.slot_count = slot_inc;
                        nxt.phase      = pwfd_pkg::PH_LEAD;
                        finish         = (slot_inc >= SLOTS_LAST);
                    end
                end
                pwfd_pkg::PH_TAIL: begin
                    if (!tail_ok) begin
                        finish = 1'b1;
                    end else begin
                        nxt.shift_code = code_shift;
                        nxt.bit_count  = bits_inc;
                        nxt.slot_count = slot_inc;
                        nxt.phase      = pwfd_pkg::PH_LEAD;
                        finish         = (slot_inc >= SLOTS_LAST);
                    end
                end
                default: ;
            endcase
        end
        if (finish) begin
            nxt.phase = pwfd_pkg::PH_IDLE;
        end
    end

    assign state_o             = nxt;
    assign emit_o              = finish;
    assign result_o.code       = nxt.shift_code;
    assign result_o.bits_taken = nxt.bit_count;
    assign result_o.command    = pwfd_pkg::cmd_from_code(nxt.shift_code);

endmodule

@@ hdl/rf_pulse_width_frame_decoder_unit.sv @@
// ============================================================================
// Pulse width frame decoder
// Decodes sync, lead and tail pulse widths into a short code and a command.
// ============================================================================
//
//  channel  dir  transfer carries
//  -------  ---  ------------------------------------------------------------
//  s_*      in   one measured pulse: tdata pulse_ticks, tuser frame_start
//  m_*      out  one finished frame: tdata code, bits_taken, command
//  cfg_*    in   one window limit write, index 0..7, no handshake back
//
//  Cycles: two-stage pipeline, input register then result register; one pulse
//  per cycle while m_* is not stalled; a frame result is decoded from its last
//  pulse in the input register and shows on m_* from the result register.
//  The frame state update per pulse is window compares and, on a good tail, a shift.
//  Reset: synchronous active-low aresetn; clears frame state, both valid
//  flags and restores the default window limits.
//  Stalls: a held result blocks the input register only when that register
//  is full and its pulse cannot advance; s_tready follows that condition.
//
module rf_pulse_width_frame_decoder_unit (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pwfd_pkg::TICK_W-1:0]     s_tdata,   // [7:0] pulse_ticks
    input  logic [0:0]                      s_tuser,   // [0] frame_start

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pwfd_pkg::MDATA_W-1:0]    m_tdata,   // [3:0] code, [6:4] bits_taken,
                                                       // [8:7] command, rest zero

    input  logic                            cfg_wr_en,
    input  logic [pwfd_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [pwfd_pkg::CFG_W-1:0]      cfg_data
);

    pwfd_pkg::cfg_t                   cfg;

    // Input register
    logic                             stg_valid_reg;
    logic                             stg_valid_next;
    logic                             stg_start_reg;
    logic [pwfd_pkg::TICK_W-1:0]      stg_ticks_reg;

    // Frame state
    pwfd_pkg::dec_state_t             state_reg;
    pwfd_pkg::dec_state_t             state_next;

    // Result register
    logic                             m_valid_reg;
    logic                             m_valid_next;
    pwfd_pkg::result_t                res_reg;

    pwfd_pkg::result_t                dec_result;
    logic                             dec_emit;
    logic                             out_free;
    logic                             stg_adv;
    logic                             s_fire;

    pwfd_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    pwfd_slot_logic u_slot_logic (
        .cfg_i    (cfg),
        .state_i  (state_reg),
        .start_i  (stg_start_reg),
        .ticks_i  (stg_ticks_reg),
        .state_o  (state_next),
        .emit_o   (dec_emit),
        .result_o (dec_result)
    );

    // Advance the staged pulse whenever the result register can take a result
    assign out_free = !m_valid_reg || m_tready;
    assign stg_adv  = stg_valid_reg && out_free;
    assign s_tready = !stg_valid_reg || stg_adv;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (s_fire) begin
            stg_valid_next = 1'b1;
        end else if (stg_adv) begin
            stg_valid_next = 1'b0;
        end
    end

    // Hold a result until taken; load a new one when a frame ends
    always_comb begin
        m_valid_next = m_valid_reg;
        if (stg_adv && dec_emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg          <= 1'b0;
            m_valid_reg            <= 1'b0;
            state_reg.phase        <= pwfd_pkg::PH_IDLE;
            state_reg.lead_was_one <= 1'b0;
            state_reg.slot_count   <= '0;
            state_reg.bit_count    <= '0;
            state_reg.shift_code   <= '0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            m_valid_reg   <= m_valid_next;
            if (stg_adv) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            stg_start_reg <= s_tuser[0];
            stg_ticks_reg <= s_tdata;
        end
        if (stg_adv && dec_emit) begin
            res_reg <= dec_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(pwfd_pkg::MDATA_W - pwfd_pkg::RES_W){1'b0}},
                       res_reg.command, res_reg.bits_taken, res_reg.code};

`ifndef SYNTHESIS
    // A frame end always lands in the result register
    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (stg_adv && dec_emit) |=> m_valid_reg)
        else $error("frame end did not produce a result");

    // Command agrees with the code it was decoded from
    a_cmd_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.command == pwfd_pkg::CMD_ON) |->
        (res_reg.code == pwfd_pkg::CODE_ON))
        else $error("on command with wrong code");

    a_cmd_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.command == pwfd_pkg::CMD_OFF) |->
        (res_reg.code == pwfd_pkg::CODE_OFF))
        else $error("off command with wrong code");

    // Slot counter never runs past the frame length
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(state_reg.slot_count) <= pwfd_pkg::BIT_SLOTS)
        else $error("slot counter past frame length");

    // No more bits than slots in a result
    a_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (int'(res_reg.bits_taken) <= pwfd_pkg::BIT_SLOTS))
        else $error("bits_taken exceeds slot count");
`endif

endmodule
